// ===== hdl/pit_pkg.sv =====
// Shared types and constants for the prescaled interval timer.
`default_nettype none

package pit_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // Register offsets
  localparam logic [2:0] OFF_CS    = 3'd0;
  localparam logic [2:0] OFF_MOD   = 3'd2;
  localparam logic [2:0] OFF_COUNT = 3'd4;

  // Control/status bit positions
  localparam int CS_EN_BIT   = 0;
  localparam int CS_RLD_BIT  = 1;
  localparam int CS_PIF_BIT  = 2;
  localparam int CS_PIE_BIT  = 3;
  localparam int CS_OVW_BIT  = 4;
  localparam int CS_PRE_LSB  = 8;
  localparam int CS_PRE_MSB  = 11;

  localparam logic [15:0] CS_PIE_MASK = 16'h0008;
  localparam logic [15:0] FULL16      = 16'hffff;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  reg_offset;
    logic [15:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq;
    logic        bad_offset;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/pit_if.sv =====
// Request channels of the timer: command in, response out.
`default_nettype none

interface pit_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  reg_offset;
  logic [15:0] write_data;

  modport source (output valid, output mode, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input mode, input reg_offset, input write_data,
                output ready);
endinterface

interface pit_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq;
  logic        bad_offset;

  modport source (output valid, output read_data, output irq, output bad_offset,
                  input ready);
  modport sink (input valid, input read_data, input irq, input bad_offset,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/pit_core.sv =====
// Timer register file and single-request update logic.
`default_nettype none

module pit_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire pit_pkg::cmd_t cmd,
  output pit_pkg::rsp_t      result
);

  logic [15:0] control_status, control_status_next;
  logic [15:0] modulus, modulus_next;
  logic [15:0] count, count_next;
  logic [14:0] prescale_count, prescale_count_next;

  logic [15:0] period;
  logic [15:0] pcnt_inc;
  logic [15:0] limit;
  logic [15:0] cs_wr;
  logic [3:0]  pre;
  logic        good_off;

  assign pre      = control_status[pit_pkg::CS_PRE_MSB:pit_pkg::CS_PRE_LSB];
  assign period   = 16'(1) << pre;
  assign pcnt_inc = {1'b0, prescale_count} + 16'd1;
  assign limit    = control_status[pit_pkg::CS_RLD_BIT] ? modulus : pit_pkg::FULL16;
  assign good_off = (cmd.reg_offset == pit_pkg::OFF_CS) ||
                    (cmd.reg_offset == pit_pkg::OFF_MOD) ||
                    (cmd.reg_offset == pit_pkg::OFF_COUNT);

  // Flag is write-one-to-clear; writing zero keeps it
  always_comb begin
    cs_wr = cmd.write_data;
    cs_wr[pit_pkg::CS_PIF_BIT] = cmd.write_data[pit_pkg::CS_PIF_BIT] ? 1'b0 :
                                 control_status[pit_pkg::CS_PIF_BIT];
  end

  // Next state for one request
  always_comb begin
    control_status_next = control_status;
    modulus_next        = modulus;
    count_next          = count;
    prescale_count_next = prescale_count;
    unique case (pit_pkg::mode_t'(cmd.mode))
      pit_pkg::MODE_TICK: begin
        if (control_status[pit_pkg::CS_EN_BIT]) begin
          if (pcnt_inc < period) begin
            prescale_count_next = pcnt_inc[14:0];
          end else begin
            prescale_count_next = '0;
            if (count <= 16'd1) begin
              control_status_next[pit_pkg::CS_PIF_BIT] = 1'b1;
              count_next = limit;
            end else begin
              count_next = count - 16'd1;
            end
          end
        end
      end
      pit_pkg::MODE_WRITE: begin
        if (cmd.reg_offset == pit_pkg::OFF_CS) begin
          control_status_next = cs_wr;
          // Restart the prescaler when any bit other than the interrupt enable changes
          if (((control_status ^ cs_wr) & ~pit_pkg::CS_PIE_MASK) != '0) begin
            prescale_count_next = '0;
          end
        end else if (cmd.reg_offset == pit_pkg::OFF_MOD) begin
          modulus_next = cmd.write_data;
          control_status_next[pit_pkg::CS_PIF_BIT] = 1'b0;
          if (control_status[pit_pkg::CS_OVW_BIT]) begin
            count_next          = cmd.write_data;
            prescale_count_next = '0;
          end
        end
      end
      pit_pkg::MODE_READ, pit_pkg::MODE_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Response fields
  always_comb begin
    result.read_data  = '0;
    result.bad_offset = 1'b0;
    if (cmd.mode == pit_pkg::MODE_READ) begin
      priority if (cmd.reg_offset == pit_pkg::OFF_CS)    result.read_data = control_status;
      else if (cmd.reg_offset == pit_pkg::OFF_MOD)       result.read_data = modulus;
      else if (cmd.reg_offset == pit_pkg::OFF_COUNT)     result.read_data = count;
      else                                               result.read_data = '0;
    end
    if (cmd.mode == pit_pkg::MODE_READ || cmd.mode == pit_pkg::MODE_WRITE) begin
      result.bad_offset = !good_off;
    end
    result.irq = control_status_next[pit_pkg::CS_PIE_BIT] &
                 control_status_next[pit_pkg::CS_PIF_BIT];
  end

  // Commit state when the request leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      control_status <= '0;
      modulus        <= '0;
      count          <= '0;
      prescale_count <= '0;
    end else if (step) begin
      control_status <= control_status_next;
      modulus        <= modulus_next;
      count          <= count_next;
      prescale_count <= prescale_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/prescaled_interval_timer.sv =====
// Top level: input stage, timer core and response register.
// A request accepted into the input stage passes through the core into the response register.
// Throughput: one request per cycle; the input stage keeps taking requests while
// a response waits, and stalls only when both stages are full.
// The input stage and the response register form a two-deep pipe around the core.
// Synchronous reset clears all timer registers and empties both stages.
`default_nettype none

module prescaled_interval_timer (
  input  wire logic  clk,
  input  wire logic  rst,
  pit_cmd_if.sink    cmd,
  pit_rsp_if.source  rsp
);

  logic          in_valid;
  pit_pkg::cmd_t in_cmd;
  logic          out_valid;
  pit_pkg::rsp_t out_rsp;
  pit_pkg::rsp_t core_rsp;
  logic          advance;

  // Move the held request into the response register when it is free or its response is being taken
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !in_valid || advance;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_cmd <= '{mode: cmd.mode, reg_offset: cmd.reg_offset, write_data: cmd.write_data};
    end
  end

  pit_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cmd    (in_cmd),
    .result (core_rsp)
  );

  // Hold the response until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= core_rsp;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_rsp.read_data;
  assign rsp.irq        = out_rsp.irq;
  assign rsp.bad_offset = out_rsp.bad_offset;

endmodule

`default_nettype wire

// ===== hdl/pit_checker.sv =====
// Port-level checks for the timer and their binding to the top level.
`default_nettype none

module pit_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] rsp_read_data,
  input wire logic        rsp_bad_offset
);

  // A stalled response stays offered
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // An accepted request shows up as a valid response
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> ##1 rsp_valid)
    else $error("accepted request produced no response");

  // With nothing waiting on the output side, requests are taken
  assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> cmd_ready)
    else $error("request refused with empty output");

  // A bad offset never returns data
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_bad_offset |-> rsp_read_data == 16'd0)
    else $error("bad offset returned data");

endmodule

bind prescaled_interval_timer pit_checker u_pit_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_data  (rsp.read_data),
  .rsp_bad_offset (rsp.bad_offset)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the prescaled interval timer: directed table, then random traffic.

module testbench;
  import pit_pkg::*;

  localparam int TOTAL_ITEMS    = 650;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_DIRECTED   = 26;

  // Control/status masks; the single-bit ones are built from the package bit positions
  localparam logic [15:0] EN_MASK  = 16'h1 << CS_EN_BIT;
  localparam logic [15:0] RLD_MASK = 16'h1 << CS_RLD_BIT;
  localparam logic [15:0] PIF_MASK = 16'h1 << CS_PIF_BIT;
  localparam logic [15:0] OVW_MASK = 16'h1 << CS_OVW_BIT;
  localparam logic [15:0] PRE_MASK = 16'h0f00;
  // Bits with no function (debug, doze and spare), stored and read back only
  localparam logic [15:0] SPARE_MASK = 16'hf0e0;

  // Offsets outside the register window
  localparam logic [2:0] OFF_BAD1 = 3'd1;
  localparam logic [2:0] OFF_BAD3 = 3'd3;
  localparam logic [2:0] OFF_BAD7 = 3'd7;

  typedef struct {
    mode_t       kind;
    logic [2:0]  off;
    logic [15:0] data;
    bit          typed;
    logic [15:0] rd;
    logic        irq;
    logic        bad;
  } dir_row_t;

  // Directed requests; typed rows carry their response, the rest use the predictor
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{MODE_READ,  OFF_CS,    16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
    '{MODE_READ,  OFF_MOD,   16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
    '{MODE_READ,  OFF_COUNT, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
    '{MODE_READ,  OFF_BAD1,  16'h0000, 1'b1, 16'h0000, 1'b0, 1'b1},
    '{MODE_READ,  OFF_BAD7,  16'h0000, 1'b1, 16'h0000, 1'b0, 1'b1},
    '{MODE_WRITE, OFF_BAD3,  FULL16,   1'b1, 16'h0000, 1'b0, 1'b1},
    '{MODE_NOP,   OFF_BAD7,  FULL16,   1'b1, 16'h0000, 1'b0, 1'b0},
    '{MODE_TICK,  OFF_CS,    16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_COUNT, 16'h1234, 1'b1, 16'h0000, 1'b0, 1'b0},
    '{MODE_READ,  OFF_COUNT, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_CS,    EN_MASK | CS_PIE_MASK | OVW_MASK, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_MOD,   16'h0002, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_TICK,  OFF_CS,    16'h0000, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_TICK,  OFF_CS,    16'h0000, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_READ,  OFF_COUNT, 16'h0000, 1'b1, FULL16,   1'b1, 1'b0},
    '{MODE_WRITE, OFF_CS,    EN_MASK | CS_PIE_MASK | OVW_MASK | PIF_MASK,
      1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_CS,    EN_MASK | RLD_MASK | OVW_MASK, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_MOD,   16'h0000, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_TICK,  OFF_CS,    16'h0000, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_TICK,  OFF_CS,    16'h0000, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_CS,    PRE_MASK | EN_MASK | RLD_MASK | CS_PIE_MASK | OVW_MASK,
      1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_TICK,  OFF_CS,    16'h0000, 1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_CS,    PRE_MASK | EN_MASK | RLD_MASK | OVW_MASK,
      1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_MOD,   FULL16,   1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_WRITE, OFF_CS,    FULL16,   1'b0, 16'h0, 1'b0, 1'b0},
    '{MODE_READ,  OFF_CS,    16'h0000, 1'b0, 16'h0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst;

  pit_cmd_if cmd_ch ();
  pit_rsp_if rsp_ch ();

  prescaled_interval_timer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Timer state as the predictor sees it
  logic [15:0] pit_cs;
  logic [15:0] pit_mod;
  logic [15:0] pit_count;
  logic [14:0] pit_phase;

  rsp_t responses_due [$];
  logic row_typed;
  rsp_t row_want;
  bit   idle_on;
  int   items;
  int   mismatches;
  int   quiet_cycles;
  int   stall_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one request to the predicted timer state and form its response
  task automatic timer_next(input mode_t kind, input logic [2:0] off,
                            input logic [15:0] data, output rsp_t resp);
    int          period;
    logic [15:0] limit;
    logic [15:0] next_cs;
    resp = '0;
    case (kind)
      MODE_TICK: begin
        if (pit_cs[CS_EN_BIT]) begin
          period = 1 << pit_cs[CS_PRE_MSB:CS_PRE_LSB];
          if (int'(pit_phase) + 1 < period) begin
            pit_phase = pit_phase + 15'd1;
          end else begin
            pit_phase = '0;
            limit = pit_cs[CS_RLD_BIT] ? pit_mod : FULL16;
            // Expire at one or zero: set the flag and reload
            if (pit_count <= 16'd1) begin
              pit_cs[CS_PIF_BIT] = 1'b1;
              pit_count = limit;
            end else begin
              pit_count = pit_count - 16'd1;
            end
          end
        end
      end
      MODE_READ: begin
        case (off)
          OFF_CS:    resp.read_data = pit_cs;
          OFF_MOD:   resp.read_data = pit_mod;
          OFF_COUNT: resp.read_data = pit_count;
          default:   resp.bad_offset = 1'b1;
        endcase
      end
      MODE_WRITE: begin
        case (off)
          OFF_CS: begin
            // Writing one clears the flag, zero keeps it
            next_cs = data & ~PIF_MASK;
            if (!data[CS_PIF_BIT]) next_cs[CS_PIF_BIT] = pit_cs[CS_PIF_BIT];
            // Keep the prescaler phase only when nothing but the interrupt enable moves
            if (((pit_cs ^ next_cs) & ~CS_PIE_MASK) != 16'h0) pit_phase = '0;
            pit_cs = next_cs;
          end
          OFF_MOD: begin
            pit_mod = data;
            pit_cs[CS_PIF_BIT] = 1'b0;
            if (pit_cs[CS_OVW_BIT]) begin
              pit_count = data;
              pit_phase = '0;
            end
          end
          OFF_COUNT: ;
          default: resp.bad_offset = 1'b1;
        endcase
      end
      default: ;
    endcase
    resp.irq = pit_cs[CS_PIE_BIT] & pit_cs[CS_PIF_BIT];
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Drive one request from a falling edge and return at the falling edge after it is taken
  task automatic issue(input mode_t kind, input logic [2:0] off, input logic [15:0] data);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid      = 1'b1;
    cmd_ch.mode       = kind;
    cmd_ch.reg_offset = off;
    cmd_ch.write_data = data;
    do @(posedge clk); while (!cmd_ch.ready);
    items++;
    @(negedge clk);
  endtask

  // Response side: stall in random bursts while idling is on
  initial begin
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        stall_left = 0;
        rsp_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 14);
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Predict on each taken request, check each taken response
  always @(posedge clk) begin
    rsp_t predicted;
    rsp_t want;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        timer_next(mode_t'(cmd_ch.mode), cmd_ch.reg_offset, cmd_ch.write_data, predicted);
        responses_due.push_back(row_typed ? row_want : predicted);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (responses_due.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = responses_due.pop_front();
          if (rsp_ch.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      rsp_ch.read_data, want.read_data));
          if (rsp_ch.irq !== want.irq)
            report_mismatch($sformatf("irq got %b want %b", rsp_ch.irq, want.irq));
          if (rsp_ch.bad_offset !== want.bad_offset)
            report_mismatch($sformatf("bad_offset got %b want %b",
                                      rsp_ch.bad_offset, want.bad_offset));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0] ctl;
    logic [15:0] mod_val;
    logic [3:0]  pre;
    int          seq_len;
    int          pick;
    cmd_ch.valid      = 1'b0;
    cmd_ch.mode       = '0;
    cmd_ch.reg_offset = '0;
    cmd_ch.write_data = '0;
    rst          = 1'b1;
    row_typed    = 1'b0;
    row_want     = '0;
    idle_on      = 1'b1;
    items        = 0;
    pit_cs       = '0;
    pit_mod      = '0;
    pit_count    = '0;
    pit_phase    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row_typed = directed_rows[i].typed;
      row_want.read_data  = directed_rows[i].rd;
      row_want.irq        = directed_rows[i].irq;
      row_want.bad_offset = directed_rows[i].bad;
      issue(directed_rows[i].kind, directed_rows[i].off, directed_rows[i].data);
    end
    row_typed = 1'b0;

    // Random traffic: mostly set-up-and-tick sequences, some noise
    while (items < TOTAL_ITEMS) begin
      idle_on = (items < TOTAL_ITEMS - 60) && (((items / 80) % 4) != 3);
      if ($urandom_range(0, 9) < 7) begin
        // Program control: mostly enabled with a short prescaler
        pre = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(3, 15))
                                          : 4'($urandom_range(0, 2));
        ctl = ($urandom_range(0, 9) == 0) ? 16'h0000 : EN_MASK;
        if ($urandom_range(0, 1)) ctl = ctl | RLD_MASK;
        if ($urandom_range(0, 1)) ctl = ctl | CS_PIE_MASK;
        if ($urandom_range(0, 2) != 0) ctl = ctl | OVW_MASK;
        if ($urandom_range(0, 3) == 0) ctl = ctl | PIF_MASK;
        if ($urandom_range(0, 3) == 0) ctl = ctl | (16'($urandom) & SPARE_MASK);
        ctl = ctl | ({12'h0, pre} << CS_PRE_LSB);
        issue(MODE_WRITE, OFF_CS, ctl);
        // Load a mostly small modulus
        mod_val = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        issue(MODE_WRITE, OFF_MOD, mod_val);
        // Tick with reads and flag handling mixed in
        seq_len = $urandom_range(2, 24);
        for (int k = 0; k < seq_len; k++) begin
          pick = $urandom_range(0, 9);
          case (pick)
            6:       issue(MODE_READ, OFF_COUNT, 16'($urandom));
            7:       issue(MODE_READ, OFF_CS, 16'($urandom));
            8:       issue(MODE_WRITE, OFF_CS, pit_cs | PIF_MASK);
            9:       issue(MODE_WRITE, OFF_CS, (pit_cs ^ CS_PIE_MASK) & ~PIF_MASK);
            default: issue(MODE_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
          endcase
        end
      end else begin
        issue(mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 16'($urandom));
      end
    end
    cmd_ch.valid = 1'b0;
    idle_on = 1'b0;

    // Drain, then let the pipe settle
    while (responses_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== prescaled_interval_timer.f =====
hdl/pit_pkg.sv
hdl/pit_if.sv
hdl/pit_core.sv
hdl/prescaled_interval_timer.sv
hdl/pit_checker.sv
sim/testbench.sv
